@@ src/dmx_pkg.sv @@
// Shared types and codes for the DMX512 frame receiver.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package dmx_pkg;

	typedef logic [1:0]  op_t;
	typedef logic [8:0]  word_t;
	typedef logic [8:0]  slot_t;
	typedef logic [7:0]  byte_t;
	typedef logic [15:0] ticks_t;

	// Operation codes
	localparam op_t OP_WORD = 2'd0;
	localparam op_t OP_TICK = 2'd1;
	localparam op_t OP_ACK  = 2'd2;
	localparam op_t OP_READ = 2'd3;

	// Stop-bit position in the nine-bit word, the break pattern, timer limits
	localparam int     STOP_BIT        = 8;
	localparam word_t  BREAK_WORD      = 9'h000;
	localparam ticks_t TIMER_MAX       = 16'hFFFF;
	localparam ticks_t TIMEOUT_DEFAULT = 16'd100;

endpackage

@@ src/dmx_cmd_if.sv @@
// Command and result channels of the DMX512 frame receiver.
// Depends on dmx_pkg for payload types.
interface dmx_cmd_if;
	logic            valid;
	logic            ready;
	dmx_pkg::op_t    op;
	dmx_pkg::word_t  rx_word;
	dmx_pkg::slot_t  slot_index;

	modport source (output valid, output op, output rx_word, output slot_index, input ready);
	modport sink   (input valid, input op, input rx_word, input slot_index, output ready);
endinterface

interface dmx_rsp_if;
	logic            valid;
	logic            ready;
	logic            frame_done;
	logic            receiving;
	logic            armed;
	dmx_pkg::slot_t  slot_count;
	dmx_pkg::byte_t  read_data;

	modport source (output valid, output frame_done, output receiving, output armed,
		output slot_count, output read_data, input ready);
	modport sink   (input valid, input frame_done, input receiving, input armed,
		input slot_count, input read_data, output ready);
endinterface

@@ src/dmx512_frame_receiver_top.sv @@
// DMX512 frame receiver: control registers, slot memory and result pipeline.
// Depends on dmx_pkg and on the dmx_cmd_if / dmx_rsp_if interfaces.
//
// One command word is taken every clock cycle unless the result path is stalled; its
// result word passes through stage 1 and then the output register. The accepting cycle
// updates the frame control state and issues at most one access to the slot memory (a
// store for a data word, a registered read for a read command); stage 1 then holds that
// registered read data while the output register is busy. Commands do not depend on
// stored slot bytes, so a read right after a store of the same slot sees the new byte
// without stalling. The slot memory has no reset and needs no clearing pass; reading a
// slot never written since reset returns an unspecified byte. The gap timeout register
// should only be written while no command is in flight.
module dmx512_frame_receiver_top #(
	parameter int SLOT_COUNT = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  dmx_pkg::ticks_t       cfg_wdata,
	dmx_cmd_if.sink               cmd,
	dmx_rsp_if.source             rsp
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
	localparam logic [9:0]    SLOT_LIMIT = 10'(SLOT_COUNT);

	// Control state
	logic [AW-1:0]    write_slot_q;
	logic             armed_q;
	logic             running_q;
	logic             done_q;
	dmx_pkg::ticks_t  gap_q;
	dmx_pkg::ticks_t  timeout_q;

	// Slot memory
	logic [7:0]       slot_mem [SLOT_COUNT];

	// Stage 1 and output register
	logic             valid_s1;
	logic             done_s1;
	logic             recv_s1;
	logic             armed_s1;
	logic [AW-1:0]    slot_s1;
	logic             rden_s1;
	dmx_pkg::byte_t   rdata_s1;

	logic             out_valid_q;
	logic             out_done_q;
	logic             out_recv_q;
	logic             out_armed_q;
	dmx_pkg::slot_t   out_slot_q;
	dmx_pkg::byte_t   out_rdata_q;

	logic             s1_adv;
	logic             accept;

	// Next control state
	logic [AW-1:0]    write_slot_d;
	logic             armed_d;
	logic             running_d;
	logic             done_d;
	dmx_pkg::ticks_t  gap_d;
	dmx_pkg::ticks_t  tick_val;
	logic             is_data;
	logic             mem_we;
	logic             mem_re;

	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || s1_adv;
	assign accept    = cmd.valid && cmd.ready;

	assign is_data  = cmd.rx_word[dmx_pkg::STOP_BIT];
	assign tick_val = (gap_q < dmx_pkg::TIMER_MAX) ? gap_q + 16'd1 : gap_q;
	assign mem_we   = accept && (cmd.op == dmx_pkg::OP_WORD) && is_data && armed_q;
	assign mem_re   = accept && (cmd.op == dmx_pkg::OP_READ)
		&& ({1'b0, cmd.slot_index} < SLOT_LIMIT);

	// Work out the state update of one command
	always_comb begin
		write_slot_d = write_slot_q;
		armed_d      = armed_q;
		running_d    = running_q;
		done_d       = done_q;
		gap_d        = gap_q;
		case (cmd.op)
			dmx_pkg::OP_WORD: begin
				if (!is_data) begin
					if (cmd.rx_word == dmx_pkg::BREAK_WORD) begin
						armed_d = 1'b1;
					end
				end else if (armed_q) begin
					running_d = 1'b1;
					gap_d     = '0;
					if (write_slot_q == LAST_SLOT) begin
						write_slot_d = '0;
						armed_d      = 1'b0;
						done_d       = 1'b1;
					end else begin
						write_slot_d = write_slot_q + AW'(1);
					end
				end
			end
			dmx_pkg::OP_TICK: begin
				if (running_q) begin
					if (tick_val > timeout_q) begin
						gap_d     = '0;
						running_d = 1'b0;
						done_d    = 1'b1;
						armed_d   = 1'b0;
					end else begin
						gap_d = tick_val;
					end
				end
			end
			dmx_pkg::OP_ACK: begin
				if (done_q) begin
					done_d       = 1'b0;
					write_slot_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold control state and the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			armed_q      <= 1'b0;
			running_q    <= 1'b0;
			done_q       <= 1'b0;
			gap_q        <= '0;
			timeout_q    <= dmx_pkg::TIMEOUT_DEFAULT;
		end else begin
			if (accept) begin
				write_slot_q <= write_slot_d;
				armed_q      <= armed_d;
				running_q    <= running_d;
				done_q       <= done_d;
				gap_q        <= gap_d;
			end
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	// Store a slot byte or read one; read data holds until the next read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[write_slot_q] <= cmd.rx_word[7:0];
		end
		if (mem_re) begin
			rdata_s1 <= slot_mem[cmd.slot_index[AW-1:0]];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1  <= done_d;
			recv_s1  <= running_d;
			armed_s1 <= armed_d;
			slot_s1  <= write_slot_d;
			rden_s1  <= mem_re;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; read data is zero unless this word read a slot
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_done_q  <= done_s1;
			out_recv_q  <= recv_s1;
			out_armed_q <= armed_s1;
			out_slot_q  <= 9'(slot_s1);
			out_rdata_q <= rden_s1 ? rdata_s1 : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.frame_done = out_done_q;
	assign rsp.receiving  = out_recv_q;
	assign rsp.armed      = out_armed_q;
	assign rsp.slot_count = out_slot_q;
	assign rsp.read_data  = out_rdata_q;

	// A stalled stage 1 keeps its read data
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> $stable(rdata_s1))
		else $error("slot read data changed while stage 1 was stalled");

	// An acknowledge of a finished frame clears done and the slot counter
	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == dmx_pkg::OP_ACK && done_q |=> !done_q && write_slot_q == '0)
		else $error("acknowledge did not clear the frame state");

	// A stored byte starts the gap timer over and marks data running
	a_data_restarts_gap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> running_q && gap_q == '0)
		else $error("stored byte did not restart the gap timer");

	// The output register only loads when it is free or being emptied
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !s1_adv)
		else $error("output register overwritten while stalled");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for dmx512_frame_receiver_top: directed and random command words,
// each result word checked against an in-bench frame state model.
// Depends on dmx_pkg, dmx_cmd_if, dmx_rsp_if and the receiver top level.
module tb;

	localparam int SLOTS       = 512;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic            frame_done;
		logic            receiving;
		logic            armed;
		dmx_pkg::slot_t  slot_count;
		dmx_pkg::byte_t  read_data;
	} status_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	dmx_pkg::ticks_t cfg_wdata;

	dmx_cmd_if cmd_ch ();
	dmx_rsp_if rsp_ch ();

	dmx512_frame_receiver_top #(.SLOT_COUNT(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// Frame state model
	dmx_pkg::byte_t  slot_mem [SLOTS];
	bit              slot_written [SLOTS];
	dmx_pkg::slot_t  written_q [$];
	dmx_pkg::slot_t  next_slot;
	bit              brk_armed;
	bit              running;
	bit              done;
	dmx_pkg::ticks_t gap_count;
	dmx_pkg::ticks_t gap_limit;

	status_t status_q [$];
	int      n_errors;
	int      n_sent;
	int      cycles;
	bit      src_gaps_on;
	bit      sink_stalls_on;
	bit      hold_rsp;

	// Toggle the clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Advance the model by one command word and queue the status it produces
	task automatic predict_status(dmx_pkg::op_t op, dmx_pkg::word_t w, dmx_pkg::slot_t idx);
		status_t s;
		s.read_data = '0;
		case (op)
			dmx_pkg::OP_WORD: begin
				if (!w[dmx_pkg::STOP_BIT]) begin
					if (w == dmx_pkg::BREAK_WORD)
						brk_armed = 1'b1;
				end else if (brk_armed) begin
					running   = 1'b1;
					gap_count = '0;
					slot_mem[next_slot] = w[7:0];
					if (!slot_written[next_slot]) begin
						slot_written[next_slot] = 1'b1;
						written_q.push_back(next_slot);
					end
					if (int'(next_slot) == SLOTS - 1) begin
						next_slot = '0;
						brk_armed = 1'b0;
						done      = 1'b1;
					end else begin
						next_slot = next_slot + 1'b1;
					end
				end
			end
			dmx_pkg::OP_TICK: begin
				if (running) begin
					if (gap_count != dmx_pkg::TIMER_MAX)
						gap_count = gap_count + 1'b1;
					if (gap_count > gap_limit) begin
						gap_count = '0;
						running   = 1'b0;
						done      = 1'b1;
						brk_armed = 1'b0;
					end
				end
			end
			dmx_pkg::OP_ACK: begin
				if (done) begin
					done      = 1'b0;
					next_slot = '0;
				end
			end
			default: begin
				s.read_data = slot_mem[idx];
			end
		endcase
		s.frame_done = done;
		s.receiving  = running;
		s.armed      = brk_armed;
		s.slot_count = next_slot;
		status_q.push_back(s);
	endtask

	// Offer one command word, wait for the handshake, then predict its status
	task automatic send_cmd(dmx_pkg::op_t op, dmx_pkg::word_t w, dmx_pkg::slot_t idx);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.rx_word    <= w;
		cmd_ch.slot_index <= idx;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		predict_status(op, w, idx);
		n_sent++;
	endtask

	task automatic send_word(dmx_pkg::word_t w);
		send_cmd(dmx_pkg::OP_WORD, w, dmx_pkg::slot_t'($urandom));
	endtask

	task automatic send_tick();
		send_cmd(dmx_pkg::OP_TICK, dmx_pkg::word_t'($urandom), dmx_pkg::slot_t'($urandom));
	endtask

	task automatic send_ack();
		send_cmd(dmx_pkg::OP_ACK, dmx_pkg::word_t'($urandom), dmx_pkg::slot_t'($urandom));
	endtask

	task automatic send_read(dmx_pkg::slot_t idx);
		send_cmd(dmx_pkg::OP_READ, dmx_pkg::word_t'($urandom), idx);
	endtask

	// Read back some slot that holds a byte; never touch an unwritten one
	task automatic send_read_any();
		if (written_q.size() > 0)
			send_read(written_q[$urandom_range(0, written_q.size() - 1)]);
	endtask

	// Drop valid and wait until every queued status has come back
	task automatic wait_all_results();
		cmd_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the gap timeout with the block idle
	task automatic write_timeout(dmx_pkg::ticks_t v);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gap_limit = v;
	endtask

	// Accept result words, stalling at random or for one long hold
	initial begin : rsp_sink
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_stalls_on ? $urandom_range(0, 16) : 0;
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors < 60)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : check_rsp
		status_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (status_q.size() == 0) begin
				n_errors++;
				if (n_errors < 60)
					$display("%0t: unexpected result, expected none actual slot_count %0h",
						$time, rsp_ch.slot_count);
			end else begin
				want = status_q.pop_front();
				check_field("frame_done", 16'(want.frame_done), 16'(rsp_ch.frame_done));
				check_field("receiving", 16'(want.receiving), 16'(rsp_ch.receiving));
				check_field("armed", 16'(want.armed), 16'(rsp_ch.armed));
				check_field("slot_count", 16'(want.slot_count), 16'(rsp_ch.slot_count));
				check_field("read_data", 16'(want.read_data), 16'(rsp_ch.read_data));
			end
		end
	end

	// Idle block: stray ack, tick and words must change nothing
	task automatic test_idle_ignores();
		send_ack();
		send_tick();
		send_word(9'h1A5);
		send_word(9'h0FF);
		send_word(9'h001);
		send_word(9'h080);
	endtask

	// Short frames under the shortest timeouts, including reads right after stores
	task automatic test_short_frames();
		src_gaps_on = 1'b0;
		write_timeout(16'd0);
		send_word(dmx_pkg::BREAK_WORD);
		send_word(9'h100);
		send_word(9'h1FF);
		send_read(9'd0);
		send_word(9'h1C3);
		send_read(9'd2);
		send_read(9'd1);
		send_tick();
		send_ack();
		send_ack();
		write_timeout(16'd1);
		send_word(dmx_pkg::BREAK_WORD);
		send_word(9'h17E);
		send_tick();
		send_word(9'h181);
		send_tick();
		send_tick();
		send_word(9'h1AA);
		send_tick();
		send_ack();
		write_timeout(dmx_pkg::TIMEOUT_DEFAULT);
		src_gaps_on = 1'b1;
	endtask

	// Full 512-slot frame, readback of slots spread over the frame, then a late timeout
	task automatic test_full_frame();
		int k;
		send_word(dmx_pkg::BREAK_WORD);
		for (k = 0; k < SLOTS; k++) begin
			if (k == 0)
				send_word(9'h100);
			else if (k == SLOTS - 1)
				send_word(9'h1FF);
			else
				send_word(dmx_pkg::word_t'({1'b1, dmx_pkg::byte_t'($urandom)}));
		end
		for (k = 0; k < SLOTS; k += 8)
			send_read(dmx_pkg::slot_t'(k));
		send_read(dmx_pkg::slot_t'(SLOTS - 1));
		repeat (50) send_tick();
		send_ack();
		repeat (60) send_tick();
		send_ack();
	endtask

	// Hold off results for a long stretch while commands keep coming
	task automatic test_backpressure();
		int k;
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b1;
		hold_rsp       = 1'b1;
		send_word(dmx_pkg::BREAK_WORD);
		for (k = 0; k < 40; k++) begin
			case ($urandom_range(0, 2))
				0: send_tick();
				1: send_read_any();
				default: send_word(dmx_pkg::word_t'({1'b1, dmx_pkg::byte_t'($urandom)}));
			endcase
		end
		wait_all_results();
		src_gaps_on = 1'b1;
	endtask

	// Run the gap timer well up under the largest timeout, then let a small one fire
	task automatic test_timer_saturation();
		int k;
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		write_timeout(dmx_pkg::TIMER_MAX);
		send_word(dmx_pkg::BREAK_WORD);
		send_word(9'h15A);
		for (k = 0; k < 200; k++)
			send_tick();
		write_timeout(16'd3);
		send_tick();
		send_ack();
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	// One break-led frame with random bytes, ticks and reads
	task automatic run_frame();
		int n;
		int k;
		int t;
		if ($urandom_range(0, 3) == 0)
			send_word(dmx_pkg::word_t'($urandom_range(1, 255)));
		send_word(dmx_pkg::BREAK_WORD);
		n = ($urandom_range(0, 24) == 0) ? $urandom_range(480, 530) : $urandom_range(1, 24);
		for (k = 0; k < n; k++) begin
			send_word(dmx_pkg::word_t'({1'b1, dmx_pkg::byte_t'($urandom)}));
			if ($urandom_range(0, 3) == 0)
				send_tick();
			if ($urandom_range(0, 5) == 0)
				send_read_any();
		end
		// let the gap run out when the timeout is short
		t = 0;
		while (running && gap_limit < 40 && t <= int'(gap_limit) + 1) begin
			send_tick();
			t++;
		end
		if ($urandom_range(0, 1) == 0)
			send_read_any();
		if ($urandom_range(0, 3) != 0)
			send_ack();
	endtask

	// A burst of unstructured command words
	task automatic run_noise();
		int n;
		int k;
		dmx_pkg::op_t op;
		n = $urandom_range(1, 8);
		for (k = 0; k < n; k++) begin
			op = dmx_pkg::op_t'($urandom_range(0, 3));
			case (op)
				dmx_pkg::OP_WORD: begin
					if ($urandom_range(0, 3) == 0)
						send_word(dmx_pkg::BREAK_WORD);
					else
						send_word(dmx_pkg::word_t'($urandom_range(0, 511)));
				end
				dmx_pkg::OP_TICK: send_tick();
				dmx_pkg::OP_ACK:  send_ack();
				default: begin
					if (written_q.size() > 0)
						send_read_any();
					else
						send_tick();
				end
			endcase
		end
	endtask

	// Random traffic over several timeout settings
	task automatic test_random_traffic();
		int phase;
		int target;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_timeout(16'd1);
				1: write_timeout(dmx_pkg::TIMER_MAX);
				default: write_timeout(dmx_pkg::ticks_t'($urandom_range(2, 30)));
			endcase
			target = n_sent + 120;
			while (n_sent < target) begin
				src_gaps_on    = ($urandom_range(0, 3) != 0);
				sink_stalls_on = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) < 7)
					run_frame();
				else
					run_noise();
			end
		end
		write_timeout(dmx_pkg::TIMEOUT_DEFAULT);
	endtask

	initial begin
		n_errors       = 0;
		n_sent         = 0;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		hold_rsp       = 1'b0;
		next_slot      = '0;
		brk_armed      = 1'b0;
		running        = 1'b0;
		done           = 1'b0;
		gap_count      = '0;
		gap_limit      = dmx_pkg::TIMEOUT_DEFAULT;
		foreach (slot_written[i]) begin
			slot_written[i] = 1'b0;
			slot_mem[i]     = '0;
		end
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.op         <= dmx_pkg::OP_WORD;
		cmd_ch.rx_word    <= '0;
		cmd_ch.slot_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_ignores();
		test_short_frames();
		test_full_frame();
		test_backpressure();
		test_timer_saturation();
		test_random_traffic();

		wait_all_results();
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
